@@ design/thl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package thl_pkg;

  localparam int OP_W            = 2;
  localparam int REQ_ID_W        = 8;
  localparam int TICKET_W        = 16;
  localparam int STATUS_W        = 3;
  localparam int ID_BITS_DEF     = 8;
  localparam int TICKET_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOCK        = 2'd0,
    OP_UNLOCK      = 2'd1,
    OP_ISSUE       = 2'd2,
    OP_TICKET_LOCK = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_WAIT      = 3'd1,
    ST_DEADLOCK  = 3'd2,
    ST_NOT_OWNER = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [REQ_ID_W-1:0] requester;
    logic [TICKET_W-1:0] ticket_in;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [TICKET_W-1:0] ticket_out;
  } rsp_t;

  typedef struct packed {
    logic held;
    logic owner_valid;
    logic tickets_out;
    logic ticket_idle;
  } lock_flags_t;

endpackage

`default_nettype wire

@@ design/thl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface thl_req_if import thl_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [REQ_ID_W-1:0] requester;
  logic [TICKET_W-1:0] ticket_in;

  modport source (output valid, operation, requester, ticket_in, input ready);
  modport sink   (input valid, operation, requester, ticket_in, output ready);
endinterface

interface thl_rsp_if import thl_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [TICKET_W-1:0] ticket_out;

  modport source (output valid, status, ticket_out, input ready);
  modport sink   (input valid, status, ticket_out, output ready);
endinterface

`default_nettype wire

@@ design/ticket_handoff_lock.sv @@
// A request accepted from in_req enters the input register, then passes through the decision logic
//   into the result register, which drives out_rsp. Throughput: one request per cycle
//   unless out_rsp stalls; lock state updates as a request enters the result register.
// Reset (rst_n low, synchronous): no owner, lock free, no tickets out, both ticket counters zero,
//   both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module ticket_handoff_lock import thl_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input wire          clk,
  input wire          rst_n,
  thl_req_if.sink     in_req,
  thl_rsp_if.source   out_rsp
);

  req_t        req_s;
  req_t        s1_req;
  logic        s1_valid;
  logic        s2_ready;
  rsp_t        core_rsp;
  rsp_t        out_s;
  lock_flags_t flags;
  logic        fire;

  assign req_s.operation = in_req.operation;
  assign req_s.requester = in_req.requester;
  assign req_s.ticket_in = in_req.ticket_in;

  assign fire = s1_valid && s2_ready;

  thl_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_req   (req_s),
    .in_ready (in_req.ready),
    .adv      (s2_ready),
    .s_valid  (s1_valid),
    .s_req    (s1_req)
  );

  thl_core #(
    .ID_BITS     (ID_BITS),
    .TICKET_BITS (TICKET_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (s1_req),
    .rsp   (core_rsp),
    .flags (flags)
  );

  thl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_rsp    (core_rsp),
    .in_ready  (s2_ready),
    .out_valid (out_rsp.valid),
    .out_rsp   (out_s),
    .out_ready (out_rsp.ready)
  );

  assign out_rsp.status     = out_s.status;
  assign out_rsp.ticket_out = out_s.ticket_out;

  a_held_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    flags.held |-> flags.owner_valid)
    else $error("lock held without an owner");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !flags.tickets_out |-> flags.ticket_idle)
    else $error("ticket counters not cleared while no tickets out");

  a_ticket_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_rsp.ticket_out != '0)) |-> (out_rsp.status == ST_OK))
    else $error("ticket returned with a failing status");

  a_request_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_rsp.valid)
    else $error("request lost between stages");

endmodule

`default_nettype wire

@@ design/thl_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module thl_in_stage import thl_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  req_t in_req,
  output logic in_ready,
  input  wire  adv,
  output logic s_valid,
  output req_t s_req
);

  logic valid_r;
  req_t req_r;

  assign in_ready = !valid_r || adv;
  assign s_valid  = valid_r;
  assign s_req    = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

endmodule

`default_nettype wire

@@ design/thl_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module thl_core import thl_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         fire,
  input  req_t        req,
  output rsp_t        rsp,
  output lock_flags_t flags
);

  // compare width wide enough for both the stored ticket and the presented one
  localparam int CW = (TICKET_BITS > TICKET_W) ? TICKET_BITS : TICKET_W;

  logic [ID_BITS-1:0]     owner_r, owner_nxt;
  logic                   owner_valid_r, owner_valid_nxt;
  logic                   held_r, held_nxt;
  logic                   tickets_out_r, tickets_out_nxt;
  logic [TICKET_BITS-1:0] serving_r, serving_nxt;
  logic [TICKET_BITS-1:0] last_r, last_nxt;

  logic [ID_BITS-1:0]     who;
  logic [CW-1:0]          tk_w;
  logic [CW-1:0]          serving_w;
  logic [CW-1:0]          last_w;
  logic [TICKET_BITS-1:0] next_tk;
  logic [TICKET_BITS-1:0] issued;
  logic                   is_owner;
  status_t                status;

  assign who       = ID_BITS'(req.requester);
  assign tk_w      = CW'(req.ticket_in);
  assign serving_w = CW'(serving_r);
  assign last_w    = CW'(last_r);
  assign next_tk   = last_r + TICKET_BITS'(1);
  assign is_owner  = owner_valid_r && (owner_r == who);

  always_comb begin
    owner_nxt       = owner_r;
    owner_valid_nxt = owner_valid_r;
    held_nxt        = held_r;
    tickets_out_nxt = tickets_out_r;
    serving_nxt     = serving_r;
    last_nxt        = last_r;
    status          = ST_OK;
    issued          = '0;
    unique case (req.operation)
      OP_LOCK: begin
        if (is_owner && !tickets_out_r) begin
          status = ST_DEADLOCK;
        end else if (held_r || tickets_out_r) begin
          status = ST_WAIT;
        end else begin
          held_nxt        = 1'b1;
          owner_nxt       = who;
          owner_valid_nxt = 1'b1;
        end
      end
      OP_UNLOCK: begin
        if (!is_owner) begin
          status = ST_NOT_OWNER;
        end else if (tickets_out_r) begin
          serving_nxt = serving_r + TICKET_BITS'(1);
        end else begin
          held_nxt        = 1'b0;
          owner_nxt       = '0;
          owner_valid_nxt = 1'b0;
        end
      end
      OP_ISSUE: begin
        if (next_tk == serving_r) begin
          status = ST_EXHAUSTED;
        end else begin
          issued          = next_tk;
          tickets_out_nxt = 1'b1;
          last_nxt        = next_tk;
        end
      end
      OP_TICKET_LOCK: begin
        if (!tickets_out_r) begin
          status = ST_INVALID;
        end else if (serving_w != tk_w) begin
          status = ST_WAIT;
        end else begin
          owner_nxt       = who;
          owner_valid_nxt = 1'b1;
          // last ticket handed over: ticket state back to idle
          if (last_w == tk_w) begin
            tickets_out_nxt = 1'b0;
            serving_nxt     = '0;
            last_nxt        = '0;
          end
        end
      end
    endcase
  end

  assign rsp.status     = status;
  assign rsp.ticket_out = TICKET_W'(issued);

  assign flags.held        = held_r;
  assign flags.owner_valid = owner_valid_r;
  assign flags.tickets_out = tickets_out_r;
  assign flags.ticket_idle = (serving_r == '0) && (last_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r       <= '0;
      owner_valid_r <= 1'b0;
      held_r        <= 1'b0;
      tickets_out_r <= 1'b0;
      serving_r     <= '0;
      last_r        <= '0;
    end else if (fire) begin
      owner_r       <= owner_nxt;
      owner_valid_r <= owner_valid_nxt;
      held_r        <= held_nxt;
      tickets_out_r <= tickets_out_nxt;
      serving_r     <= serving_nxt;
      last_r        <= last_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/thl_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module thl_out_stage import thl_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  rsp_t in_rsp,
  output logic in_ready,
  output logic out_valid,
  output rsp_t out_rsp,
  input  wire  out_ready
);

  logic valid_r;
  rsp_t rsp_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rsp_r <= in_rsp;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/ticket_handoff_lock_checker.sv @@
`timescale 1ns / 1ps

module ticket_handoff_lock_checker import thl_pkg::*; #(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  thl_req_if   req,
  thl_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  localparam logic [31:0] ID_MASK = (ID_BITS >= 32) ? 32'hFFFF_FFFF :
                                    ((32'd1 << ID_BITS) - 32'd1);
  localparam logic [31:0] TK_MASK = (TICKET_BITS >= 32) ? 32'hFFFF_FFFF :
                                    ((32'd1 << TICKET_BITS) - 32'd1);

  logic [31:0] owner_id;
  logic        owner_valid;
  logic        held;
  logic        tickets_out;
  logic [31:0] serving_tk;
  logic [31:0] last_tk;

  rsp_t answers_due[$];

  function automatic rsp_t grant_request(input op_t op,
                                         input logic [REQ_ID_W-1:0] requester,
                                         input logic [TICKET_W-1:0] ticket);
    rsp_t        res;
    logic [31:0] who;
    logic [31:0] tk;
    logic [31:0] next_tk;
    logic        is_owner;
    who        = 32'(requester) & ID_MASK;
    tk         = 32'(ticket);
    is_owner   = owner_valid && (owner_id == who);
    res.status     = ST_OK;
    res.ticket_out = '0;
    case (op)
      OP_LOCK: begin
        if (is_owner && !tickets_out) begin
          res.status = ST_DEADLOCK;
        end else if (held || tickets_out) begin
          res.status = ST_WAIT;
        end else begin
          held        = 1'b1;
          owner_id    = who;
          owner_valid = 1'b1;
        end
      end
      OP_UNLOCK: begin
        if (!is_owner) begin
          res.status = ST_NOT_OWNER;
        end else if (tickets_out) begin
          serving_tk = (serving_tk + 32'd1) & TK_MASK;
        end else begin
          held        = 1'b0;
          owner_id    = '0;
          owner_valid = 1'b0;
        end
      end
      OP_ISSUE: begin
        next_tk = (last_tk + 32'd1) & TK_MASK;
        if (next_tk == serving_tk) begin
          res.status = ST_EXHAUSTED;
        end else begin
          res.ticket_out = next_tk[TICKET_W-1:0];
          tickets_out    = 1'b1;
          last_tk        = next_tk;
        end
      end
      default: begin
        if (!tickets_out) begin
          res.status = ST_INVALID;
        end else if (serving_tk != tk) begin
          res.status = ST_WAIT;
        end else begin
          owner_id    = who;
          owner_valid = 1'b1;
          // last ticket taken: ticket state back to idle
          if (last_tk == tk) begin
            tickets_out = 1'b0;
            serving_tk  = '0;
            last_tk     = '0;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      owner_id    = '0;
      owner_valid = 1'b0;
      held        = 1'b0;
      tickets_out = 1'b0;
      serving_tk  = '0;
      last_tk     = '0;
      answers_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          $display("%0t: expected no response, got status %0d ticket %0d",
                   $time, rsp.status, rsp.ticket_out);
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
          end
          if (rsp.ticket_out !== want.ticket_out) begin
            fail_count++;
            $display("%0t: ticket_out expected %0d, got %0d",
                     $time, want.ticket_out, rsp.ticket_out);
          end
        end
      end
      if (req.valid && req.ready) begin
        answers_due.push_back(grant_request(req.operation, req.requester, req.ticket_in));
      end
    end
    pending = answers_due.size();
  end

endmodule

@@ tb/sv/ticket_handoff_lock_tb.sv @@
`timescale 1ns / 1ps

module ticket_handoff_lock_tb;
  import thl_pkg::*;

  localparam int ID_BITS_TB     = ID_BITS_DEF;
  localparam int TICKET_BITS_TB = TICKET_BITS_DEF;
  localparam int RANDOM_ITEMS   = 600;
  localparam int CALM_ITEMS     = 120;
  localparam int CYCLE_LIMIT    = 1200000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   sent_count;
  int   calm_start;
  bit   gaps_on;
  bit   stalls_on;
  int   stall_left;

  thl_req_if req_if ();
  thl_rsp_if rsp_if ();

  ticket_handoff_lock #(
    .ID_BITS     (ID_BITS_TB),
    .TICKET_BITS (TICKET_BITS_TB)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  ticket_handoff_lock_checker #(
    .ID_BITS     (ID_BITS_TB),
    .TICKET_BITS (TICKET_BITS_TB)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // response back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  function automatic logic [REQ_ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) begin
      return REQ_ID_W'($urandom);
    end
    return REQ_ID_W'($urandom_range(0, 3));
  endfunction

  task automatic send_req(input op_t op, input logic [REQ_ID_W-1:0] who,
                          input logic [TICKET_W-1:0] tk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.requester <= who;
    req_if.ticket_in <= tk;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // requests that leave the lock state alone, apart from extra tickets
  task automatic stray_requests(input logic [REQ_ID_W-1:0] owner, input int s,
                                input bit tickets, input bit locked, inout int k);
    logic [REQ_ID_W-1:0] who;
    logic [TICKET_W-1:0] tk;
    int                  n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      who = pick_id();
      tk  = TICKET_W'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          if (tickets && tk == TICKET_W'(s)) tk = ~tk;
          send_req(OP_TICKET_LOCK, who, tk);
        end
        1: begin
          if (who == owner) who = ~who;
          send_req(OP_UNLOCK, who, tk);
        end
        2: begin
          if (tickets || locked) send_req(OP_LOCK, who, tk);
        end
        default: begin
          if (tickets && k < 6) begin
            send_req(OP_ISSUE, who, tk);
            k++;
          end
        end
      endcase
    end
  endtask

  // one full handoff round from an idle lock back to an idle lock
  task automatic handoff_round(input bit allow_idle);
    logic [REQ_ID_W-1:0] owner;
    int                  k;
    int                  s;
    bit                  locked;
    bit                  tickets;
    gaps_on   = allow_idle && ($urandom_range(0, 3) != 0);
    stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
    owner   = pick_id();
    locked  = ($urandom_range(0, 3) != 0);
    k       = $urandom_range(0, 4);
    s       = 0;
    tickets = 1'b0;
    if (!locked && k == 0) k = 1;
    if (locked) begin
      send_req(OP_LOCK, owner, TICKET_W'($urandom));
      stray_requests(owner, s, tickets, locked, k);
    end
    for (int i = 0; i < k; i++) begin
      send_req(OP_ISSUE, pick_id(), TICKET_W'($urandom));
      tickets = 1'b1;
      stray_requests(owner, s, tickets, locked, k);
    end
    if (!locked) begin
      owner = pick_id();
      send_req(OP_TICKET_LOCK, owner, '0);
      stray_requests(owner, s, tickets, locked, k);
    end
    while (s < k) begin
      send_req(OP_UNLOCK, owner, TICKET_W'($urandom));
      s++;
      stray_requests(owner, s, tickets, locked, k);
      owner = pick_id();
      send_req(OP_TICKET_LOCK, owner, TICKET_W'(s));
      if (s == k) tickets = 1'b0;
      stray_requests(owner, s, tickets, locked, k);
    end
    send_req(OP_UNLOCK, owner, TICKET_W'($urandom));
  endtask

  initial begin
    rst_n            = 1'b0;
    gaps_on          = 1'b0;
    stalls_on        = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_LOCK;
    req_if.requester = '0;
    req_if.ticket_in = '0;
    repeat (10) @(negedge clk);
    rst_n    <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    send_req(OP_LOCK,        8'd0,   16'h0000);
    send_req(OP_LOCK,        8'd0,   16'hFFFF);  // owner relock
    send_req(OP_LOCK,        8'd255, 16'h0000);
    send_req(OP_UNLOCK,      8'd255, 16'hFFFF);  // foreign unlock
    send_req(OP_TICKET_LOCK, 8'd255, 16'h0000);  // no tickets out
    send_req(OP_ISSUE,       8'd0,   16'hFFFF);
    send_req(OP_LOCK,        8'd0,   16'h0000);
    send_req(OP_TICKET_LOCK, 8'd255, 16'h0001);  // not yet served
    send_req(OP_TICKET_LOCK, 8'd255, 16'hFFFF);
    send_req(OP_UNLOCK,      8'd0,   16'h0000);
    send_req(OP_TICKET_LOCK, 8'd255, 16'h0001);  // last ticket used
    send_req(OP_LOCK,        8'd0,   16'h0000);
    send_req(OP_LOCK,        8'd255, 16'h0000);
    send_req(OP_UNLOCK,      8'd0,   16'h0000);
    send_req(OP_UNLOCK,      8'd255, 16'h0000);
    send_req(OP_UNLOCK,      8'd0,   16'h0000);
    send_req(OP_ISSUE,       8'd255, 16'h0000);
    send_req(OP_TICKET_LOCK, 8'd170, 16'h0000);  // owner without hold
    send_req(OP_LOCK,        8'd85,  16'h5555);
    send_req(OP_UNLOCK,      8'd170, 16'hAAAA);
    send_req(OP_TICKET_LOCK, 8'd85,  16'h0001);
    send_req(OP_LOCK,        8'd170, 16'h0000);
    send_req(OP_UNLOCK,      8'd170, 16'h0000);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) handoff_round(1'b1);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;

    calm_start = sent_count;
    while (sent_count - calm_start < CALM_ITEMS) handoff_round(1'b0);

    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
